// ----- src/pifs_pkg.sv -----
`default_nettype none

package pifs_pkg;

  localparam int unsigned MAX_FIELDS_DEF   = 16;
  localparam int unsigned MAX_WAVE_DEF     = 255;
  localparam int unsigned CORDIC_STEPS_DEF = 30;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned TRUNC_W = 8;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned TERM_W  = 34;
  localparam int unsigned CRD_W   = 34;
  localparam int unsigned TRIG_W  = 32;
  localparam int unsigned ATAN_W  = 30;
  localparam int unsigned ATAN_IW = 6;

  localparam logic signed [CRD_W-1:0]  CORDIC_X0 = 34'sd652032874;
  localparam logic signed [CRD_W-1:0]  Q30_POS   = 34'sd1073741824;
  localparam logic signed [CRD_W-1:0]  Q30_NEG   = -34'sd1073741824;
  localparam logic signed [PROD_W-1:0] RND_HALF  = 64'sd536870912;

  localparam logic [1:0] REG_TRUNCATION  = 2'd0;
  localparam logic [1:0] REG_FIELD_COUNT = 2'd1;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_real;
    logic signed [COEF_W-1:0] coef_imag;
    logic [ANGLE_W-1:0]       longitude;
  } pifs_item_t;

  typedef struct packed {
    logic [POS_W-1:0]        field_index;
    logic signed [SUM_W-1:0] field_value;
    logic                    last_field;
  } pifs_result_t;

  typedef struct packed {
    logic             rd_en;
    logic             mul_re;
    logic             mul_im;
    logic             term_en;
    logic             wr_en;
    logic             clr;
    logic [CNT_W-1:0] addr;
  } pifs_mac_ctrl_t;

  function automatic logic [ATAN_W-1:0] pifs_atan(input logic [ATAN_IW-1:0] idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      6'd0:    r = 30'd536870912;
      6'd1:    r = 30'd316933406;
      6'd2:    r = 30'd167458907;
      6'd3:    r = 30'd85004756;
      6'd4:    r = 30'd42667331;
      6'd5:    r = 30'd21354465;
      6'd6:    r = 30'd10679838;
      6'd7:    r = 30'd5340245;
      6'd8:    r = 30'd2670163;
      6'd9:    r = 30'd1335087;
      6'd10:   r = 30'd667544;
      6'd11:   r = 30'd333772;
      6'd12:   r = 30'd166886;
      6'd13:   r = 30'd83443;
      6'd14:   r = 30'd41722;
      6'd15:   r = 30'd20861;
      6'd16:   r = 30'd10430;
      6'd17:   r = 30'd5215;
      6'd18:   r = 30'd2608;
      6'd19:   r = 30'd1304;
      6'd20:   r = 30'd652;
      6'd21:   r = 30'd326;
      6'd22:   r = 30'd163;
      6'd23:   r = 30'd81;
      6'd24:   r = 30'd41;
      6'd25:   r = 30'd20;
      6'd26:   r = 30'd10;
      6'd27:   r = 30'd5;
      6'd28:   r = 30'd3;
      6'd29:   r = 30'd1;
      6'd30:   r = 30'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] pifs_clamp_q30(
      input logic signed [CRD_W-1:0] v);
    logic signed [CRD_W-1:0] r;
    if (v > Q30_POS) begin
      r = Q30_POS;
    end else if (v < Q30_NEG) begin
      r = Q30_NEG;
    end else begin
      r = v;
    end
    return r[TRIG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/pifs_cordic.sv -----
`default_nettype none

module pifs_cordic import pifs_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [ANGLE_W-1:0]       angle_i,
  output logic                          done_o,
  output logic signed [TRIG_W-1:0]      cos_o,
  output logic signed [TRIG_W-1:0]      sin_o
);

  localparam int unsigned SW = $clog2(CORDIC_STEPS);

  logic signed [CRD_W-1:0] x_q, y_q, z_q;
  logic signed [CRD_W-1:0] x_d, y_d, z_d;
  logic [SW-1:0]           step_q;
  logic                    run_q, fin_q, done_q, flip_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  logic [1:0]              quad;
  logic                    flip_d;
  logic [ANGLE_W-1:0]      ang_f;
  logic signed [CRD_W-1:0] xs, ys, at, xf, yf;
  logic                    last_step;

  assign quad   = angle_i[ANGLE_W-1:ANGLE_W-2];
  assign flip_d = (quad == 2'b01) || (quad == 2'b10);
  assign ang_f  = flip_d ? {~angle_i[ANGLE_W-1], angle_i[ANGLE_W-2:0]} : angle_i;

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  assign at = $signed({{(CRD_W-ATAN_W){1'b0}}, pifs_atan(ATAN_IW'(step_q))});

  always_comb begin
    if (!z_q[CRD_W-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  assign xf        = flip_q ? -x_q : x_q;
  assign yf        = flip_q ? -y_q : y_q;
  assign last_step = (step_q == SW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= run_q && last_step;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        if (last_step) begin
          run_q <= 1'b0;
        end else begin
          step_q <= step_q + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      z_q    <= {{(CRD_W-ANGLE_W){ang_f[ANGLE_W-1]}}, ang_f};
      flip_q <= flip_d;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (fin_q) begin
      cos_q <= pifs_clamp_q30(xf);
      sin_q <= pifs_clamp_q30(yf);
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

`default_nettype wire

// ----- src/pifs_mac.sv -----
`default_nettype none

module pifs_mac import pifs_pkg::*; #(
  parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pifs_mac_ctrl_t           ctrl_i,
  input  wire logic signed [TRIG_W-1:0] cos_i,
  input  wire logic signed [TRIG_W-1:0] sin_i,
  input  wire logic signed [COEF_W-1:0] re_i,
  input  wire logic signed [COEF_W-1:0] im_i,
  output logic signed [SUM_W-1:0]       acc_o
);

  localparam int unsigned AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  logic signed [SUM_W-1:0]  mem_q [MAX_FIELDS];
  logic [MAX_FIELDS-1:0]    valid_q;
  logic signed [SUM_W-1:0]  rd_data_q;
  logic                     rd_valid_q;
  logic signed [PROD_W-1:0] pre_q, pim_q;
  logic signed [TERM_W-1:0] term_q;

  logic [AW-1:0]            idx;
  logic                     wr_ok;
  logic signed [TRIG_W-1:0] mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod, rnd;
  logic signed [SUM_W-1:0]  acc_cur, sat;
  logic signed [SUM_W:0]    sum;

  assign idx   = AW'(ctrl_i.addr);
  assign wr_ok = ctrl_i.wr_en && (32'(ctrl_i.addr) < MAX_FIELDS);

  assign mul_a = ctrl_i.mul_im ? sin_i : cos_i;
  assign mul_b = ctrl_i.mul_im ? im_i : re_i;
  assign prod  = PROD_W'(mul_a * mul_b);
  assign rnd   = pre_q - pim_q + RND_HALF;

  assign acc_cur = rd_valid_q ? rd_data_q : '0;
  assign sum     = {acc_cur[SUM_W-1], acc_cur}
                 + {{(SUM_W+1-TERM_W){term_q[TERM_W-1]}}, term_q};

  always_comb begin
    if (sum[SUM_W] != sum[SUM_W-1]) begin
      sat = sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat = sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (wr_ok) begin
        valid_q[idx] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[idx] <= sat;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_re) begin
      pre_q <= prod;
    end
    if (ctrl_i.mul_im) begin
      pim_q <= prod;
    end
    if (ctrl_i.term_en) begin
      term_q <= rnd[PROD_W-1:PROD_W-TERM_W];
    end
  end

  assign acc_o = acc_cur;

endmodule

`default_nettype wire

// ----- src/point_inverse_fourier_sum.sv -----
// Busy holds from acceptance until the transaction is done; a new one is accepted only while busy is low.
// Each transaction runs the iterative CORDIC, one rotation step per cycle, then multiply,
// round and saturating accumulate through a single shared 32x32 multiplier.
// After the last transaction of a point, busy stays high while the fields are read out, and
// results follow one per cycle through the read and output registers; the receiver cannot stall.
// Reset clears all control state and accumulators; truncation resets to 0, field_count to 1.
`default_nettype none

module point_inverse_fourier_sum import pifs_pkg::*; #(
  parameter int unsigned MAX_FIELDS   = MAX_FIELDS_DEF,
  parameter int unsigned MAX_WAVE     = MAX_WAVE_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire pifs_item_t  item_i,
  output logic             result_strobe_o,
  output pifs_result_t     result_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ROT  = 7'b0000010,
    S_MULR = 7'b0000100,
    S_MULI = 7'b0001000,
    S_TERM = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_EMIT = 7'b1000000
  } pifs_state_e;

  pifs_state_e state_q, state_d;

  logic [TRUNC_W-1:0]       trunc_q;
  logic [CNT_W-1:0]         fcnt_q;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [TRUNC_W-1:0]       wave_q, wave_d;
  logic [ANGLE_W-1:0]       pa_q, pa_d;
  logic [ANGLE_W-1:0]       phase_q, phase_d;
  logic [CNT_W-1:0]         k_q, k_d;
  logic signed [COEF_W-1:0] re_q, im_q;
  logic                     em_v_q;
  logic [CNT_W-1:0]         em_k_q;
  logic                     em_last_q;
  logic                     out_v_q;
  pifs_result_t             out_q;

  logic                     accept, first, cfg_wr;
  logic [1:0]               reg_sel;
  logic [CNT_W-1:0]         fc1, nf;
  logic [TRUNC_W-1:0]       tr;
  logic                     row_end, k_last;
  logic [ANGLE_W-1:0]       cor_angle;
  logic                     cor_done;
  logic signed [TRIG_W-1:0] cos_v, sin_v;
  logic signed [SUM_W-1:0]  acc_v;
  pifs_mac_ctrl_t           mac_ctrl;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = {1'b0, paddr[2]};

  always_comb begin
    case (reg_sel)
      REG_TRUNCATION:  prdata = {{(32-TRUNC_W){1'b0}}, trunc_q};
      REG_FIELD_COUNT: prdata = {{(32-CNT_W){1'b0}}, fcnt_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q <= '0;
      fcnt_q  <= CNT_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_TRUNCATION:  trunc_q <= pwdata[TRUNC_W-1:0];
        REG_FIELD_COUNT: fcnt_q  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign fc1 = (fcnt_q == '0) ? CNT_W'(1) : fcnt_q;
  assign nf  = (32'(fc1) > MAX_FIELDS) ? CNT_W'(MAX_FIELDS) : fc1;
  assign tr  = (32'(trunc_q) > MAX_WAVE) ? TRUNC_W'(MAX_WAVE) : trunc_q;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign first     = (wave_q == '0) && (pos_q == '0);
  assign cor_angle = first ? '0 : phase_q;
  assign row_end   = ({1'b0, pos_q} + CNT_W'(1)) >= nf;
  assign k_last    = (k_q + CNT_W'(1)) == nf;

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    wave_d   = wave_q;
    pa_d     = pa_q;
    phase_d  = phase_q;
    k_d      = k_q;
    mac_ctrl = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_ROT;
          if (first) begin
            pa_d    = item_i.longitude;
            phase_d = '0;
          end
        end
      end
      S_ROT: begin
        if (cor_done) begin
          state_d = S_MULR;
        end
      end
      S_MULR: begin
        mac_ctrl.mul_re = 1'b1;
        mac_ctrl.rd_en  = 1'b1;
        mac_ctrl.addr   = {1'b0, pos_q};
        state_d         = S_MULI;
      end
      S_MULI: begin
        mac_ctrl.mul_im = 1'b1;
        state_d         = S_TERM;
      end
      S_TERM: begin
        mac_ctrl.term_en = 1'b1;
        state_d          = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.wr_en = 1'b1;
        mac_ctrl.addr  = {1'b0, pos_q};
        state_d        = S_IDLE;
        if (!row_end) begin
          pos_d = pos_q + POS_W'(1);
        end else begin
          pos_d = '0;
          if (wave_q < tr) begin
            wave_d  = wave_q + TRUNC_W'(1);
            phase_d = phase_q + pa_q;
          end else begin
            wave_d  = '0;
            phase_d = '0;
            k_d     = '0;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        mac_ctrl.rd_en = 1'b1;
        mac_ctrl.addr  = k_q;
        if (k_last) begin
          mac_ctrl.clr = 1'b1;
          k_d          = '0;
          state_d      = S_IDLE;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_q     <= '0;
      wave_q    <= '0;
      pa_q      <= '0;
      phase_q   <= '0;
      k_q       <= '0;
      em_v_q    <= 1'b0;
      em_k_q    <= '0;
      em_last_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      wave_q    <= wave_d;
      pa_q      <= pa_d;
      phase_q   <= phase_d;
      k_q       <= k_d;
      em_v_q    <= (state_q == S_EMIT);
      em_k_q    <= k_q;
      em_last_q <= k_last;
      out_v_q   <= em_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      re_q <= item_i.coef_real;
      im_q <= item_i.coef_imag;
    end
    if (em_v_q) begin
      out_q.field_index <= em_k_q[POS_W-1:0];
      out_q.field_value <= acc_v;
      out_q.last_field  <= em_last_q;
    end
  end

  assign result_strobe_o = out_v_q;
  assign result_o        = out_q;

  pifs_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  pifs_mac #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .cos_i  (cos_v),
    .sin_i  (sin_v),
    .re_i   (re_q),
    .im_i   (im_q),
    .acc_o  (acc_v)
  );

`ifndef SYNTHESIS
  a_done_in_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == S_ROT))
    else $error("rotation result outside rotation phase");

  a_accept_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_ROT))
    else $error("accepted transaction did not start rotation");

  a_emit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ((pos_q == '0) && (wave_q == '0) && (phase_q == '0)))
    else $error("counters not cleared during result output");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.last_field) |=> !result_strobe_o)
    else $error("result after final field of a point");
`endif

endmodule

`default_nettype wire

// ----- tb/point_inverse_fourier_sum_tb.sv -----
`timescale 1ns / 1ps

module point_inverse_fourier_sum_tb;
  import pifs_pkg::*;

  localparam int unsigned LATENCY    = CORDIC_STEPS_DEF + 8 + MAX_FIELDS_DEF + 8;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RAND_ITEMS = 125;
  localparam longint      SUM_HI     = (64'sd1 <<< 47) - 1;
  localparam longint      SUM_LO     = -(64'sd1 <<< 47);

  typedef struct packed {
    logic [7:0]         trunc;
    logic [4:0]         fcnt;
    logic [31:0]        re;
    logic [31:0]        im;
    logic [31:0]        lon;
    logic [4:0]         reps;
    logic               typed;
    logic signed [47:0] value;
  } plan_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         start;
  logic         busy;
  pifs_item_t   item_i;
  logic         result_strobe_o;
  pifs_result_t result_o;

  logic [7:0]  m_trunc = 8'd0;
  logic [4:0]  m_fcnt  = 5'd1;
  longint      m_sum [MAX_FIELDS_DEF];
  logic [7:0]  m_wave  = '0;
  logic [3:0]  m_pos   = '0;
  logic [31:0] m_lon   = '0;
  logic [31:0] m_phase = '0;

  pifs_result_t pending_sums [$];
  pifs_result_t due;
  int unsigned  mismatches  = 0;
  int unsigned  quiet_cycles = 0;

  longint atan_turns [0:30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41,
    20, 10, 5, 3, 1,
    1
  };

  plan_row_t plan [8] = '{
    '{8'd0, 5'd1,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1, 48'sd0},
    '{8'd0, 5'd1,  32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 5'd1,  1'b0, 48'sd0},
    '{8'd0, 5'd1,  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd1,  1'b0, 48'sd0},
    '{8'd1, 5'd1,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 5'd2,  1'b0, 48'sd0},
    '{8'd3, 5'd1,  32'h0001_0000, 32'h0000_0000, 32'h4000_0000, 5'd4,  1'b0, 48'sd0},
    '{8'd0, 5'd0,  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 5'd1,  1'b0, 48'sd0},
    '{8'd0, 5'd31, 32'h8000_0000, 32'h8000_0000, 32'h2000_0000, 5'd16, 1'b0, 48'sd0},
    '{8'd0, 5'd1,  32'h0000_0000, 32'h0000_0000, 32'hC000_0000, 5'd1,  1'b1, 48'sd0}
  };

  point_inverse_fourier_sum u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void cordic_sin_cos(input logic [31:0] ang, output longint c,
                                         output longint s);
    longint x, y, z, nx, a;
    logic   flip;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) begin
      ang = ang + 32'h8000_0000;
    end
    x = longint'(CORDIC_X0);
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      a = (i <= 30) ? atan_turns[i] : 0;
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - a;
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + a;
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x > longint'(Q30_POS)) ? longint'(Q30_POS) :
        (x < longint'(Q30_NEG)) ? longint'(Q30_NEG) : x;
    s = (y > longint'(Q30_POS)) ? longint'(Q30_POS) :
        (y < longint'(Q30_NEG)) ? longint'(Q30_NEG) : y;
  endfunction

  function automatic void fourier_step(input pifs_item_t it);
    int unsigned  nf;
    longint       c, s, term, acc;
    pifs_result_t r;
    nf = (m_fcnt == 0) ? 1 : m_fcnt;
    if (nf > MAX_FIELDS_DEF) begin
      nf = MAX_FIELDS_DEF;
    end
    if (m_wave == 0 && m_pos == 0) begin
      m_lon   = it.longitude;
      m_phase = '0;
    end
    cordic_sin_cos(m_phase, c, s);
    term = (c * longint'($signed(it.coef_real)) - s * longint'($signed(it.coef_imag))
            + longint'(RND_HALF)) >>> 30;
    acc = m_sum[m_pos] + term;
    if (acc > SUM_HI) begin
      acc = SUM_HI;
    end else if (acc < SUM_LO) begin
      acc = SUM_LO;
    end
    m_sum[m_pos] = acc;
    if (m_pos + 1 < nf) begin
      m_pos = m_pos + 1'b1;
      return;
    end
    m_pos = '0;
    if (m_wave < m_trunc) begin
      m_wave  = m_wave + 1'b1;
      m_phase = m_phase + m_lon;
      return;
    end
    for (int k = 0; k < nf; k++) begin
      r.field_index = 4'(k);
      r.field_value = m_sum[k][47:0];
      r.last_field  = (k + 1 == nf);
      pending_sums.push_back(r);
    end
    foreach (m_sum[k]) begin
      m_sum[k] = 0;
    end
    m_wave  = '0;
    m_phase = '0;
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3, 4:    return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_longitude();
    case ($urandom_range(0, 5))
      0:       return {2'($urandom_range(0, 3)), 30'd0};
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic drive_item(input pifs_item_t it, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    fourier_step(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] keep;
    keep = (idx == REG_TRUNCATION) ? 32'h0000_00FF : 32'h0000_001F;
    start <= 1'b0;
    do @(posedge clk_i); while (pending_sums.size() != 0 || busy);
    repeat (LATENCY) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= (value & keep) | ($urandom() & ~keep);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_TRUNCATION) begin
      m_trunc = value[7:0];
    end else begin
      m_fcnt = value[4:0];
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & keep)) begin
      $error("prdata: expected %0h, got %0h", value & keep, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: field_index %0d, field_value %0d",
               result_o.field_index, result_o.field_value);
        mismatches++;
      end else begin
        due = pending_sums.pop_front();
        if (result_o.field_index !== due.field_index) begin
          $error("field_index: expected %0d, got %0d", due.field_index, result_o.field_index);
          mismatches++;
        end
        if (result_o.field_value !== due.field_value) begin
          $error("field_value: expected %0d, got %0d", due.field_value, result_o.field_value);
          mismatches++;
        end
        if (result_o.last_field !== due.last_field) begin
          $error("last_field: expected %0d, got %0d", due.last_field, result_o.last_field);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pifs_item_t   it;
    pifs_result_t r;
    int unsigned  random_items;
    int unsigned  point_no;
    int           break_at;
    int           k;
    logic         quiet;
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    start   <= 1'b0;
    item_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].trunc != m_trunc) begin
        write_reg(REG_TRUNCATION, 32'(plan[i].trunc));
      end
      if (plan[i].fcnt != m_fcnt) begin
        write_reg(REG_FIELD_COUNT, 32'(plan[i].fcnt));
      end
      repeat (plan[i].reps) begin
        it.coef_real = plan[i].re;
        it.coef_imag = plan[i].im;
        it.longitude = plan[i].lon;
        drive_item(it, $urandom_range(0, 17));
        if (plan[i].typed) begin
          r = pending_sums.pop_back();
          r.field_value = plan[i].value;
          pending_sums.push_back(r);
        end
      end
    end

    random_items = 0;
    point_no     = 0;
    while (random_items < RAND_ITEMS || point_no < 2) begin
      if (point_no == 0) begin
        write_reg(REG_TRUNCATION, 32'd63);
        write_reg(REG_FIELD_COUNT, 32'd1);
      end else if (point_no == 1) begin
        write_reg(REG_TRUNCATION, 32'd1);
        write_reg(REG_FIELD_COUNT, 32'd16);
      end else if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_TRUNCATION, $urandom_range(0, 4));
        write_reg(REG_FIELD_COUNT,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5));
      end
      quiet    = ($urandom_range(0, 3) == 0);
      break_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 6)) : -1;
      k = 0;
      do begin
        if (k == break_at) begin
          if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_TRUNCATION, $urandom_range(0, 4));
          end else begin
            write_reg(REG_FIELD_COUNT, $urandom_range(0, 6));
          end
        end
        it.coef_real = pick_coef();
        it.coef_imag = pick_coef();
        it.longitude = pick_longitude();
        drive_item(it, quiet ? 0 : $urandom_range(0, 17));
        k++;
        random_items++;
      end while (!(m_wave == 0 && m_pos == 0));
      point_no++;
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending_sums.size() != 0);
    repeat (LATENCY) @(posedge clk_i);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
